// ----- rtl/core/ccb_pkg.sv -----
`default_nettype none

package ccb_pkg;

    // Lexical modes
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_LINECOM = 2'd1;
    localparam logic [1:0] MODE_BLOCK   = 2'd2;
    localparam logic [1:0] MODE_STRING  = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_QUOTE     = 8'h22;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // One result item
    typedef struct packed {
        logic [7:0] ch;
        logic       line_last;
        logic       run_last;
    } t_item;

    // Results caused by one input item: zero, one or two
    typedef struct packed {
        logic [1:0] cnt;
        t_item      item0;
        t_item      item1;
    } t_lex_res;

endpackage

`default_nettype wire

// ----- rtl/core/ccb_if.sv -----
`default_nettype none

interface ccb_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       line_last;

    modport source (output valid, output char_in, output line_last, input ready);
    modport sink   (input valid, input char_in, input line_last, output ready);
endinterface

interface ccb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_out;
    logic       out_line_last;
    logic       run_last;

    modport source (output valid, output char_out, output out_line_last,
                    output run_last, input ready);
    modport sink   (input valid, input char_out, input out_line_last,
                    input run_last, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ccb_lexer.sv -----
`default_nettype none

module ccb_lexer (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_char,
    input  wire logic             i_line_last,
    output ccb_pkg::t_lex_res     o_res
);

    logic [1:0] r_mode,  n_mode;
    logic       r_slash, n_slash;
    logic       r_star,  n_star;
    logic [7:0] r_prev,  n_prev;
    logic       r_start, n_start;

    logic       held_vld;
    logic [7:0] held_ch;
    logic [1:0] mode_a;
    logic       star_a;
    logic [7:0] prev_a;
    logic       start_a;
    logic       quote_ok;
    logic       main_vld;
    logic [7:0] main_ch;

    always_comb begin
        // emit the held slash first
        held_vld = r_slash;
        held_ch  = ccb_pkg::CH_SLASH;
        mode_a   = r_mode;
        star_a   = r_star;
        prev_a   = r_prev;
        start_a  = r_start;
        if (r_slash) begin
            if (i_char == ccb_pkg::CH_SLASH) begin
                held_ch = ccb_pkg::CH_SPACE;
                mode_a  = ccb_pkg::MODE_LINECOM;
            end else if (i_char == ccb_pkg::CH_STAR) begin
                held_ch = ccb_pkg::CH_SPACE;
                mode_a  = ccb_pkg::MODE_BLOCK;
                star_a  = 1'b0;
            end
            prev_a  = held_ch;
            start_a = 1'b0;
        end

        quote_ok = start_a || (prev_a != ccb_pkg::CH_BACKSLASH);

        n_mode   = mode_a;
        n_slash  = 1'b0;
        n_star   = star_a;
        main_vld = 1'b1;
        main_ch  = i_char;

        unique case (mode_a)
            ccb_pkg::MODE_NORMAL: begin
                if (i_char == ccb_pkg::CH_SLASH) begin
                    if (!i_line_last) begin
                        main_vld = 1'b0;
                        n_slash  = 1'b1;
                    end
                end else if (i_char == ccb_pkg::CH_QUOTE && quote_ok) begin
                    n_mode = ccb_pkg::MODE_STRING;
                end
            end
            ccb_pkg::MODE_LINECOM: begin
                if (i_char == ccb_pkg::CH_NEWLINE) begin
                    n_mode = ccb_pkg::MODE_NORMAL;
                end else if (i_char != ccb_pkg::CH_TAB) begin
                    main_ch = ccb_pkg::CH_SPACE;
                end
            end
            ccb_pkg::MODE_BLOCK: begin
                if (i_char == ccb_pkg::CH_SLASH && star_a) begin
                    n_star  = 1'b0;
                    n_mode  = ccb_pkg::MODE_NORMAL;
                    main_ch = ccb_pkg::CH_SPACE;
                end else if (i_char == ccb_pkg::CH_STAR) begin
                    n_star  = 1'b1;
                    main_ch = ccb_pkg::CH_SPACE;
                end else begin
                    n_star = 1'b0;
                    if (i_char != ccb_pkg::CH_NEWLINE && i_char != ccb_pkg::CH_TAB) begin
                        main_ch = ccb_pkg::CH_SPACE;
                    end
                end
            end
            ccb_pkg::MODE_STRING: begin
                if (i_char == ccb_pkg::CH_QUOTE && quote_ok) begin
                    n_mode = ccb_pkg::MODE_NORMAL;
                end
            end
            default: begin
                n_mode = ccb_pkg::MODE_NORMAL;
            end
        endcase

        // line end resets the per-line history
        if (i_line_last) begin
            n_prev  = ccb_pkg::CH_NUL;
            n_start = 1'b1;
            n_star  = 1'b0;
        end else if (main_vld) begin
            n_prev  = main_ch;
            n_start = 1'b0;
        end else begin
            n_prev  = prev_a;
            n_start = start_a;
        end

        o_res = '0;
        if (held_vld && main_vld) begin
            o_res.cnt   = 2'd2;
            o_res.item0 = '{ch: held_ch, line_last: 1'b0, run_last: 1'b0};
            o_res.item1 = '{ch: main_ch, line_last: i_line_last, run_last: 1'b1};
        end else if (held_vld) begin
            o_res.cnt   = 2'd1;
            o_res.item0 = '{ch: held_ch, line_last: 1'b0, run_last: 1'b1};
        end else if (main_vld) begin
            o_res.cnt   = 2'd1;
            o_res.item0 = '{ch: main_ch, line_last: i_line_last, run_last: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ccb_pkg::MODE_NORMAL;
            r_slash <= 1'b0;
            r_star  <= 1'b0;
            r_prev  <= ccb_pkg::CH_NUL;
            r_start <= 1'b1;
        end else if (i_step) begin
            r_mode  <= n_mode;
            r_slash <= n_slash;
            r_star  <= n_star;
            r_prev  <= n_prev;
            r_start <= n_start;
        end
    end

    // a slash is only ever held in normal mode
    a_slash_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slash |-> (r_mode == ccb_pkg::MODE_NORMAL))
        else $error("held slash outside normal mode");

    // a remembered star belongs to an open block comment
    a_star_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_star |-> (r_mode == ccb_pkg::MODE_BLOCK))
        else $error("star flag outside block comment");

    // line start means nothing emitted on this line yet
    a_start_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_prev == ccb_pkg::CH_NUL))
        else $error("line start with history");

endmodule

`default_nettype wire

// ----- rtl/core/c_comment_blanker.sv -----
`default_nettype none

// Channel   Dir  Modport            Payload
// i_text    in   ccb_in_if.sink     char_in[7:0], line_last
// o_text    out  ccb_out_if.source  char_out[7:0], out_line_last, run_last
//
// One input item per cycle while results fit in the buffer; an item enters the
// input register, is lexed there and its results land in a two-entry result
// buffer whose head drives o_text. An item giving two results waits in the
// input register until the buffer is empty. A held slash gives no result
// until the next item. Reset is synchronous and clears control state only.
// Stalls on o_text back up through the buffer into the input register.

module c_comment_blanker (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ccb_in_if.sink     i_text,
    ccb_out_if.source  o_text
);

    // input register
    logic       r_in_vld;
    logic [7:0] r_in_char;
    logic       r_in_ll;

    // result buffer, entry 0 is the head
    ccb_pkg::t_item r_buf [2];
    ccb_pkg::t_item n_buf [2];
    logic [1:0]     r_cnt, n_cnt;

    ccb_pkg::t_lex_res lex_res;
    logic              pop;
    logic              move;
    logic [1:0]        base_cnt;
    logic [1:0]        room;

    ccb_lexer u_lexer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (move),
        .i_char      (r_in_char),
        .i_line_last (r_in_ll),
        .o_res       (lex_res)
    );

    assign pop      = o_text.valid && o_text.ready;
    assign base_cnt = r_cnt - {1'b0, pop};
    assign room     = 2'd2 - base_cnt;
    // advance the lexed item only when all its results fit
    assign move     = r_in_vld && (lex_res.cnt <= room);

    assign i_text.ready = !r_in_vld || move;

    assign o_text.valid         = (r_cnt != 2'd0);
    assign o_text.char_out      = r_buf[0].ch;
    assign o_text.out_line_last = r_buf[0].line_last;
    assign o_text.run_last      = r_buf[0].run_last;

    always_comb begin
        n_buf = r_buf;
        if (pop) begin
            n_buf[0] = r_buf[1];
        end
        n_cnt = base_cnt;
        if (move) begin
            if (lex_res.cnt != 2'd0) begin
                n_buf[base_cnt[0]] = lex_res.item0;
            end
            if (lex_res.cnt == 2'd2) begin
                n_buf[1] = lex_res.item1;
            end
            n_cnt = base_cnt + lex_res.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (i_text.ready) begin
                r_in_vld <= i_text.valid;
            end
            r_cnt <= n_cnt;
        end
    end

    // payload: load on accept, no reset
    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in_char <= i_text.char_in;
            r_in_ll   <= i_text.line_last;
        end
        r_buf <= n_buf;
    end

    // buffer holds two entries at most
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result buffer overflow");

    // a two-result item only advances into an empty buffer
    a_pair_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && lex_res.cnt == 2'd2) |-> (base_cnt == 2'd0))
        else $error("result pair written over live entry");

    // a stalled item stays in the input register
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !move) |=> (r_in_vld && $stable(r_in_char) && $stable(r_in_ll)))
        else $error("stalled item lost");

endmodule

`default_nettype wire
